>>> src/pavr_pkg.sv
// ----------------------------------------------------------------------------
// pavr_pkg: shared types, constants and sine table generator
// Axis codes, the stage-1 control bundle and the Q1.15 quarter-wave sine
// used to build the lookup table at elaboration.
// ----------------------------------------------------------------------------
package pavr_pkg;

   localparam int VEC_BITS_DEF   = 16;
   localparam int ANGLE_BITS_DEF = 12;
   localparam int MAG_W          = 15;  // sine magnitude, 0..32767
   localparam int COEF_W         = 16;  // signed Q1.15 coefficient
   localparam int OP_W           = 2;

   localparam logic [OP_W-1:0] OP_X    = 2'd0;
   localparam logic [OP_W-1:0] OP_Y    = 2'd1;
   localparam logic [OP_W-1:0] OP_Z    = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE = 2'd3;

   localparam longint unsigned HALF_PI_Q48 = 64'h1921FB54442D2;
   localparam longint unsigned Q30_ONE     = 64'd1 << 30;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            sin_neg;
      logic            cos_neg;
   } ctrl_type;

   // Taylor series through x^15 in Q2.30, Horner form, rounded to Q1.15
   function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned r,
                                                      input int unsigned angle_bits);
      longint unsigned rr;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      longint unsigned q;
      rr = 64'(r);
      x  = (rr * HALF_PI_Q48 + (64'd1 << (angle_bits + 15))) >> (angle_bits + 16);
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 210;
      t  = Q30_ONE - ((x2 * t) >> 30) / 156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      q  = (s + (64'd1 << 14)) >> 15;
      if (q > 64'd32767) begin
         q = 64'd32767;
      end
      return q[MAG_W-1:0];
   endfunction

endpackage

>>> src/pavr_sine_rom.sv
// ----------------------------------------------------------------------------
// pavr_sine_rom: quarter-wave sine table, two registered read ports
// Entries 0..2^(ANGLE_BITS-2) hold the Q1.15 magnitude of the sine.
// ----------------------------------------------------------------------------
module pavr_sine_rom
   import pavr_pkg::*;
#(
   parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [ANGLE_BITS-2:0]   addr_a,
   input  logic [ANGLE_BITS-2:0]   addr_b,
   output logic [MAG_W-1:0]        data_a,
   output logic [MAG_W-1:0]        data_b
);

   localparam int QUARTER = 1 << (ANGLE_BITS - 2);

   logic [MAG_W-1:0] sine_rom [QUARTER+1];
   logic [MAG_W-1:0] data_a_ff;
   logic [MAG_W-1:0] data_b_ff;

   for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
      assign sine_rom[i] = quarter_sine(i, ANGLE_BITS);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_a_ff <= sine_rom[addr_a];
         data_b_ff <= sine_rom[addr_b];
      end
   end

   assign data_a = data_a_ff;
   assign data_b = data_b_ff;

endmodule

>>> src/pavr_rotator.sv
// ----------------------------------------------------------------------------
// pavr_rotator: product stage and round/sum stage of the plane rotation
// The two components off the rotation axis are taken as (a, b) with
// a' = a*c - b*s and b' = a*s + b*c, then mapped back to x, y, z.
// ----------------------------------------------------------------------------
module pavr_rotator
   import pavr_pkg::*;
#(
   parameter int VEC_BITS = VEC_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       adv,
   input  ctrl_type                   ctrl,
   input  logic signed [VEC_BITS-1:0] vec_x,
   input  logic signed [VEC_BITS-1:0] vec_y,
   input  logic signed [VEC_BITS-1:0] vec_z,
   input  logic        [MAG_W-1:0]    sin_mag,
   input  logic        [MAG_W-1:0]    cos_mag,
   input  logic                       reset,
   output logic signed [VEC_BITS:0]   out_x,
   output logic signed [VEC_BITS:0]   out_y,
   output logic signed [VEC_BITS:0]   out_z
);

   localparam int PW = VEC_BITS + COEF_W;   // product width
   localparam int SW = PW + 1;              // sum width
   localparam int OW = VEC_BITS + 1;

   logic signed [VEC_BITS-1:0] a_sel;
   logic signed [VEC_BITS-1:0] b_sel;
   logic signed [COEF_W-1:0]   sin_coef;
   logic signed [COEF_W-1:0]   cos_coef;

   logic signed [PW-1:0]       ac_in, bs_in, as_in, bc_in;
   logic signed [PW-1:0]       ac_ff, bs_ff, as_ff, bc_ff;
   logic [OP_W-1:0]            op2_ff;
   logic signed [VEC_BITS-1:0] x2_ff, y2_ff, z2_ff;

   logic signed [SW-1:0]       ra_sum;
   logic signed [SW-1:0]       rb_sum;
   logic signed [OW-1:0]       ra;
   logic signed [OW-1:0]       rb;
   logic signed [OW-1:0]       x2_ext, y2_ext, z2_ext;
   logic signed [OW-1:0]       out_x_in, out_y_in, out_z_in;
   logic signed [OW-1:0]       out_x_ff, out_y_ff, out_z_ff;

   // pick the rotation plane
   always_comb begin
      unique case (ctrl.op)
         OP_X: begin
            a_sel = vec_y;
            b_sel = vec_z;
         end
         OP_Y: begin
            a_sel = vec_z;
            b_sel = vec_x;
         end
         OP_Z: begin
            a_sel = vec_x;
            b_sel = vec_y;
         end
         default: begin
            a_sel = vec_x;
            b_sel = vec_y;
         end
      endcase
   end

   assign sin_coef = ctrl.sin_neg ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
   assign cos_coef = ctrl.cos_neg ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

   assign ac_in = PW'(a_sel) * PW'(cos_coef);
   assign bs_in = PW'(b_sel) * PW'(sin_coef);
   assign as_in = PW'(a_sel) * PW'(sin_coef);
   assign bc_in = PW'(b_sel) * PW'(cos_coef);

   always_ff @(posedge clock) begin
      if (adv) begin
         ac_ff  <= ac_in;
         bs_ff  <= bs_in;
         as_ff  <= as_in;
         bc_ff  <= bc_in;
         op2_ff <= ctrl.op;
         x2_ff  <= vec_x;
         y2_ff  <= vec_y;
         z2_ff  <= vec_z;
      end
   end

   // round to nearest, ties toward +inf: add half an LSB, then floor
   assign ra_sum = SW'(ac_ff) - SW'(bs_ff) + SW'(1 << 14);
   assign rb_sum = SW'(as_ff) + SW'(bc_ff) + SW'(1 << 14);
   assign ra     = ra_sum[VEC_BITS+15:15];
   assign rb     = rb_sum[VEC_BITS+15:15];

   assign x2_ext = OW'(x2_ff);
   assign y2_ext = OW'(y2_ff);
   assign z2_ext = OW'(z2_ff);

   always_comb begin
      unique case (op2_ff)
         OP_X: begin
            out_x_in = x2_ext;
            out_y_in = ra;
            out_z_in = rb;
         end
         OP_Y: begin
            out_x_in = rb;
            out_y_in = y2_ext;
            out_z_in = ra;
         end
         OP_Z: begin
            out_x_in = ra;
            out_y_in = rb;
            out_z_in = z2_ext;
         end
         default: begin
            out_x_in = x2_ext;
            out_y_in = y2_ext;
            out_z_in = z2_ext;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   assign out_x = out_x_ff;
   assign out_y = out_y_ff;
   assign out_z = out_z_ff;

   // the axis component survives the round/sum stage untouched
   a_x_pass: assert property (@(posedge clock) disable iff (reset)
      adv && (op2_ff == OP_X) |=> out_x == $past(x2_ext))
      else $error("x component altered on rotation about X");

   a_y_pass: assert property (@(posedge clock) disable iff (reset)
      adv && (op2_ff == OP_Y) |=> out_y == $past(y2_ext))
      else $error("y component altered on rotation about Y");

   a_z_pass: assert property (@(posedge clock) disable iff (reset)
      adv && (op2_ff == OP_Z) |=> out_z == $past(z2_ext))
      else $error("z component altered on rotation about Z");

endmodule

>>> src/principal_axis_vector_rotation_unit.sv
// ----------------------------------------------------------------------------
// principal_axis_vector_rotation_unit: rotate a vector about X, Y or Z
// Three-stage pipeline: sine table read, products, round and sum.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side is not stalled and
// returns one result per request, in order. The three stages are the
// registered sine/cosine table read, four parallel VEC_BITS x 16 signed
// multiplies, and the rounding add that forms each rotated component; the
// multiply stage sets the clock rate. A stall on the result side holds the
// whole pipeline, so req_tready follows rsp_tready whenever a result is
// waiting. Axis code 3 passes the vector through.
// ----------------------------------------------------------------------------
module principal_axis_vector_rotation_unit
   import pavr_pkg::*;
#(
   parameter int VEC_BITS   = VEC_BITS_DEF,
   parameter int ANGLE_BITS = ANGLE_BITS_DEF,
   localparam int REQ_W     = ((3 * VEC_BITS + ANGLE_BITS) + 7) / 8 * 8,
   localparam int RSP_W     = ((3 * (VEC_BITS + 1)) + 7) / 8 * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // vec_x, vec_y, vec_z, angle, zero pad
   input  logic [OP_W-1:0]  req_tuser,   // op (rotation axis)
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // out_x, out_y, out_z, zero pad
);

   localparam int OW      = VEC_BITS + 1;
   localparam int IDX_W   = ANGLE_BITS - 1;
   localparam int QUARTER = 1 << (ANGLE_BITS - 2);

   logic                       adv;
   logic                       v1_ff, v2_ff, v3_ff;
   logic                       v1_in, v2_in, v3_in;

   logic signed [VEC_BITS-1:0] in_x, in_y, in_z;
   logic [ANGLE_BITS-1:0]      in_angle;
   logic [1:0]                 quad_s, quad_c;
   logic [ANGLE_BITS-3:0]      rem;
   logic [IDX_W-1:0]           idx_s, idx_c;

   ctrl_type                   ctrl_in, ctrl_ff;
   logic signed [VEC_BITS-1:0] x1_ff, y1_ff, z1_ff;
   logic [MAG_W-1:0]           sin_mag, cos_mag;
   logic signed [OW-1:0]       out_x, out_y, out_z;

   assign in_x     = req_tdata[VEC_BITS-1:0];
   assign in_y     = req_tdata[2*VEC_BITS-1:VEC_BITS];
   assign in_z     = req_tdata[3*VEC_BITS-1:2*VEC_BITS];
   assign in_angle = req_tdata[3*VEC_BITS+ANGLE_BITS-1:3*VEC_BITS];

   // advance everything unless a result waits unclaimed
   assign adv        = !v3_ff || rsp_tready;
   assign req_tready = adv;

   // fold the angle into a quarter-wave index; cosine is a quarter turn ahead
   assign quad_s = in_angle[ANGLE_BITS-1:ANGLE_BITS-2];
   assign quad_c = quad_s + 2'd1;
   assign rem    = in_angle[ANGLE_BITS-3:0];
   assign idx_s  = quad_s[0] ? IDX_W'(QUARTER) - IDX_W'(rem) : IDX_W'(rem);
   assign idx_c  = quad_c[0] ? IDX_W'(QUARTER) - IDX_W'(rem) : IDX_W'(rem);

   assign ctrl_in.op      = req_tuser;
   assign ctrl_in.sin_neg = quad_s[1];
   assign ctrl_in.cos_neg = quad_c[1];

   always_comb begin
      v1_in = v1_ff;
      v2_in = v2_ff;
      v3_in = v3_ff;
      if (adv) begin
         v1_in = req_tvalid;
         v2_in = v1_ff;
         v3_in = v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff <= ctrl_in;
         x1_ff   <= in_x;
         y1_ff   <= in_y;
         z1_ff   <= in_z;
      end
   end

   pavr_sine_rom #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_sine_rom (
      .clock  (clock),
      .en     (adv),
      .addr_a (idx_s),
      .addr_b (idx_c),
      .data_a (sin_mag),
      .data_b (cos_mag)
   );

   pavr_rotator #(
      .VEC_BITS (VEC_BITS)
   ) u_rotator (
      .clock   (clock),
      .adv     (adv),
      .ctrl    (ctrl_ff),
      .vec_x   (x1_ff),
      .vec_y   (y1_ff),
      .vec_z   (z1_ff),
      .sin_mag (sin_mag),
      .cos_mag (cos_mag),
      .reset   (reset),
      .out_x   (out_x),
      .out_y   (out_y),
      .out_z   (out_z)
   );

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = RSP_W'({out_z, out_y, out_x});

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !v1_ff && !v2_ff && !v3_ff)
      else $error("pipeline not empty after reset");

   a_stage_move: assert property (@(posedge clock) disable iff (reset)
      adv && v2_ff |=> v3_ff)
      else $error("request lost between product and result stage");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> (v1_ff == $past(v1_ff)) && (v2_ff == $past(v2_ff)))
      else $error("pipeline moved while stalled");

endmodule
